// ===== hw/rtl/utf8_byte_sanitizer_top_defines.svh =====
// ----------------------------------------------------------------------------
// utf8_byte_sanitizer_top_defines.svh
// Assertion macros used by the checker file of the UTF-8 sanitizer.
// ----------------------------------------------------------------------------
`ifndef UTF8_BYTE_SANITIZER_TOP_DEFINES_SVH
`define UTF8_BYTE_SANITIZER_TOP_DEFINES_SVH

// Plain property, clocked, reset-gated.
`define UTF8S_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define UTF8S_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define UTF8S_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/utf8s_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8s_pkg
// Types, constants and decode helpers of the UTF-8 byte sanitizer.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8s_pkg;

  localparam int unsigned GrpDepth = 4;

  localparam logic [7:0] ReplReset = 8'h3F;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContVal   = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Val  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Val  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Val  = 8'hF0;

  // Group of result beats caused by one input beat.
  typedef struct packed {
    logic [GrpDepth-1:0][7:0] bytes;
    logic [2:0]               cnt;
    logic                     last;
  } grp_t;

  // Full sequence length of a lead byte, 0 if not a lead.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if ((b & Lead2Mask) == Lead2Val) begin
      len = 3'd2;
    end else if ((b & Lead3Mask) == Lead3Val) begin
      len = 3'd3;
    end else if ((b & Lead4Mask) == Lead4Val) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/utf8s_if.sv =====
// ----------------------------------------------------------------------------
// utf8s_if
// Valid/ready channels of the UTF-8 byte sanitizer: input and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface utf8s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] clean_byte;
  logic       item_done;
  logic       stream_done;

  modport source (output valid, output clean_byte, output item_done, output stream_done,
                  input ready);
  modport sink   (input valid, input clean_byte, input item_done, input stream_done,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/utf8s_core.sv =====
// ----------------------------------------------------------------------------
// utf8s_core
// Sequence tracker: holds partial sequences and builds the result group of
// each accepted input beat.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8s_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              fire_i,
  input  logic [7:0]        data_byte_i,
  input  logic              stream_end_i,
  output utf8s_pkg::grp_t   grp_o
);
  import utf8s_pkg::*;

  logic [7:0]          repl_q;
  logic [GrpDepth-1:0][7:0] held_q, held_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [2:0]          need_q, need_d;

  logic       active, cont, ascii, is_lead, complete, store, fresh;
  logic [2:0] c1, pre, flen, f_n;

  always_comb begin
    active   = (cnt_q != 3'd0) && (cnt_q < 3'd4) && (need_q > cnt_q);
    cont     = (data_byte_i & ContMask) == ContVal;
    ascii    = !data_byte_i[7];
    flen     = lead_len(data_byte_i);
    is_lead  = flen != 3'd0;
    c1       = cnt_q + 3'd1;
    complete = active && cont && (c1 == need_q);
    store    = active && cont && !complete;
    fresh    = !(active && cont);
    pre      = active ? cnt_q : 3'd0;
    f_n      = (ascii || !is_lead || stream_end_i) ? 3'd1 : 3'd0;
  end

  always_comb begin
    grp_o.last = stream_end_i;
    for (int i = 0; i < GrpDepth; i++) begin
      if (complete) begin
        grp_o.bytes[i] = (3'(i) < cnt_q) ? held_q[i] : data_byte_i;
      end else if (fresh && ascii && (3'(i) == pre)) begin
        grp_o.bytes[i] = data_byte_i;
      end else begin
        grp_o.bytes[i] = repl_q;
      end
    end
    if (complete) begin
      grp_o.cnt = c1;
    end else if (store) begin
      grp_o.cnt = stream_end_i ? c1 : 3'd0;
    end else begin
      grp_o.cnt = pre + f_n;
    end
  end

  always_comb begin
    held_d = held_q;
    cnt_d  = 3'd0;
    need_d = 3'd0;
    if (store) begin
      held_d[cnt_q[1:0]] = data_byte_i;
      if (!stream_end_i) begin
        cnt_d  = c1;
        need_d = need_q;
      end
    end else if (fresh && is_lead && !stream_end_i) begin
      held_d[0] = data_byte_i;
      cnt_d     = 3'd1;
      need_d    = flen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= ReplReset;
      cnt_q  <= 3'd0;
      need_q <= 3'd0;
    end else begin
      if (cfg_we_i) begin
        repl_q <= cfg_wdata_i;
      end
      if (fire_i) begin
        cnt_q  <= cnt_d;
        need_q <= need_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8s_ser.sv =====
// ----------------------------------------------------------------------------
// utf8s_ser
// Result register: stores one group and plays it out one beat per cycle while the sink is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8s_ser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  utf8s_pkg::grp_t  grp_i,
  output logic             free_o,
  utf8s_out_if.source      out_o
);
  import utf8s_pkg::*;

  logic [GrpDepth-1:0][7:0] bytes_q;
  logic [2:0] rem_q, rem_d;
  logic [1:0] ptr_q, ptr_d;
  logic       last_q;
  logic       out_fire;

  assign out_o.valid       = rem_q != 3'd0;
  assign out_o.clean_byte  = bytes_q[ptr_q];
  assign out_o.item_done   = rem_q == 3'd1;
  assign out_o.stream_done = (rem_q == 3'd1) && last_q;
  assign out_fire          = out_o.valid && out_o.ready;
  assign free_o            = (rem_q == 3'd0) || ((rem_q == 3'd1) && out_o.ready);

  always_comb begin
    rem_d = rem_q;
    ptr_d = ptr_q;
    if (load_i) begin
      rem_d = grp_i.cnt;
      ptr_d = 2'd0;
    end else if (out_fire) begin
      rem_d = rem_q - 3'd1;
      ptr_d = ptr_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
      ptr_q <= 2'd0;
    end else begin
      rem_q <= rem_d;
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= grp_i.bytes;
      last_q  <= grp_i.last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_byte_sanitizer_top.sv =====
// The sanitizer takes one input beat per cycle whenever its result register is
// empty or is showing its last beat while that beat is taken. ASCII and invalid
// bytes give one result beat in the cycle after they are taken. Bytes of an open
// multi-byte sequence give no beat; the byte that completes or breaks it, or
// a stream end, gives up to four beats, played out one per cycle from the
// result register while the output is ready, so input waits behind such a group
// until its last beat is taken. The replacement byte register resets to 0x3F.
// ----------------------------------------------------------------------------
// utf8_byte_sanitizer_top
// UTF-8 byte-stream sanitizer: passes valid sequences, replaces bad bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_byte_sanitizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  utf8s_in_if.sink    in_i,
  utf8s_out_if.source out_o
);
  import utf8s_pkg::*;

  grp_t grp;
  logic free;
  logic in_fire;

  assign in_i.ready = free;
  assign in_fire    = in_i.valid && free;

  utf8s_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fire_i       (in_fire),
    .data_byte_i  (in_i.data_byte),
    .stream_end_i (in_i.stream_end),
    .grp_o        (grp)
  );

  utf8s_ser u_ser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (in_fire),
    .grp_i  (grp),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/utf8s_checker.sv =====
// ----------------------------------------------------------------------------
// utf8s_checker
// Port-level checks of the UTF-8 byte sanitizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_byte_sanitizer_top_defines.svh"

module utf8s_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_end_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_item_i,
  input logic       out_sdone_i
);

  `UTF8S_ASSERT_IMP(a_sdone_item, clk_i, rst_ni, out_valid_i && out_sdone_i, out_item_i, "stream_done without item_done")
  `UTF8S_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, !out_valid_i, in_ready_i, "input stalled with empty result register")
  `UTF8S_ASSERT_NXT(a_end_emits, clk_i, rst_ni, in_valid_i && in_ready_i && in_end_i, out_valid_i, "stream end gave no result beat")
  `UTF8S_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_byte_i) && $stable(out_item_i) && $stable(out_sdone_i), "stalled result beat changed")

endmodule

bind utf8_byte_sanitizer_top utf8s_checker u_utf8s_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_end_i    (in_i.stream_end),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.clean_byte),
  .out_item_i  (out_o.item_done),
  .out_sdone_i (out_o.stream_done)
);

`default_nettype wire
